/* rtl/multi_mode_motion_integrator_macros.svh */
// ----------------------------------------------------------------------------
// multi_mode_motion_integrator_macros
// assertion helpers shared by the integrator rtl, clocked on clk, reset arst_n
// ----------------------------------------------------------------------------
`ifndef MULTI_MODE_MOTION_INTEGRATOR_MACROS_SVH
`define MULTI_MODE_MOTION_INTEGRATOR_MACROS_SVH

// condition implies consequence in the same cycle
`define MMI_ASSERT_NOW(label, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error("integrator check failed");

// condition implies consequence in the next cycle
`define MMI_ASSERT_NEXT(label, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error("integrator check failed");

`endif

/* rtl/mmi_pkg.sv */
// ----------------------------------------------------------------------------
// mmi_pkg
// types, codes and the step sequence table of the motion integrator
// ----------------------------------------------------------------------------
package mmi_pkg;

	// fixed number formats
	localparam int DT_BITS       = 16;
	localparam int GAIN_BITS     = 16;
	localparam int GAIN_FRAC     = 12;
	localparam int GRAVITY_RESET = 5000;
	localparam logic [GAIN_BITS-1:0] DRAG_GAIN_RESET = GAIN_BITS'(10 << GAIN_FRAC);
	localparam int PC_BITS       = 4;

	// register indexes
	localparam logic [1:0] REG_MODE    = 2'd0;
	localparam logic [1:0] REG_GRAVITY = 2'd1;
	localparam logic [1:0] REG_DRAG_EN = 2'd2;
	localparam logic [1:0] REG_GAIN    = 2'd3;

	// scheme codes
	localparam logic [2:0] MODE_FWD_EULER  = 3'd0;
	localparam logic [2:0] MODE_BWD_EULER  = 3'd1;
	localparam logic [2:0] MODE_SYMPLECTIC = 3'd2;
	localparam logic [2:0] MODE_POS_VERLET = 3'd3;
	localparam logic [2:0] MODE_VEL_VERLET = 3'd4;

	// command codes
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL
	} op_t;

	typedef enum logic [3:0] {
		SRC_PX,
		SRC_PY,
		SRC_VX,
		SRC_VY,
		SRC_PPX,
		SRC_PPY,
		SRC_ACC,
		SRC_GRAV,
		SRC_T,
		SRC_U,
		SRC_ZERO
	} src_t;

	typedef enum logic [2:0] {
		DST_PX,
		DST_PY,
		DST_VX,
		DST_VY,
		DST_PPX,
		DST_PPY,
		DST_T,
		DST_U
	} dst_t;

	typedef enum logic {
		MB_DT,
		MB_GAIN
	} mulb_t;

	typedef enum logic [1:0] {
		SH_12,
		SH_16,
		SH_17
	} shift_t;

	// one step of the sequence
	typedef struct packed {
		op_t    op;
		src_t   a;
		src_t   b;
		mulb_t  mb;
		shift_t sh;
		dst_t   dst;
		logic   drag_only;
		logic   last;
	} instr_t;

	function automatic logic [4:0] shift_amt(input shift_t sh);
		logic [4:0] amt;
		unique case (sh)
			SH_12:   amt = 5'd12;
			SH_16:   amt = 5'd16;
			SH_17:   amt = 5'd17;
			default: amt = 5'd16;
		endcase
		return amt;
	endfunction

	function automatic instr_t mk_mul(input src_t a, input mulb_t mb, input shift_t sh,
		input dst_t dst, input logic drag_only, input logic last);
		instr_t i;
		i.op        = OP_MUL;
		i.a         = a;
		i.b         = SRC_ZERO;
		i.mb        = mb;
		i.sh        = sh;
		i.dst       = dst;
		i.drag_only = drag_only;
		i.last      = last;
		return i;
	endfunction

	function automatic instr_t mk_alu(input op_t op, input src_t a, input src_t b,
		input dst_t dst, input logic drag_only, input logic last);
		instr_t i;
		i.op        = op;
		i.a         = a;
		i.b         = b;
		i.mb        = MB_DT;
		i.sh        = SH_16;
		i.dst       = dst;
		i.drag_only = drag_only;
		i.last      = last;
		return i;
	endfunction

	// step sequence of each scheme
	function automatic instr_t ucode(input logic [2:0] mode, input logic [PC_BITS-1:0] pc);
		instr_t nop;
		instr_t i;
		nop = mk_alu(OP_ADD, SRC_ZERO, SRC_ZERO, DST_U, 1'b0, 1'b1);
		i   = nop;
		unique case (mode)
			MODE_FWD_EULER: begin
				unique case (pc)
					4'd0:    i = mk_mul(SRC_VX, MB_DT, SH_16, DST_T, 1'b0, 1'b0);
					4'd1:    i = mk_alu(OP_ADD, SRC_PX, SRC_T, DST_PX, 1'b0, 1'b0);
					4'd2:    i = mk_mul(SRC_VY, MB_DT, SH_16, DST_T, 1'b0, 1'b0);
					4'd3:    i = mk_alu(OP_ADD, SRC_PY, SRC_T, DST_PY, 1'b0, 1'b0);
					4'd4:    i = mk_mul(SRC_ACC, MB_DT, SH_16, DST_T, 1'b0, 1'b0);
					4'd5:    i = mk_alu(OP_ADD, SRC_VY, SRC_T, DST_VY, 1'b0, 1'b0);
					4'd6:    i = mk_mul(SRC_VX, MB_DT, SH_16, DST_T, 1'b1, 1'b0);
					4'd7:    i = mk_mul(SRC_T, MB_GAIN, SH_12, DST_T, 1'b1, 1'b0);
					4'd8:    i = mk_alu(OP_SUB, SRC_VX, SRC_T, DST_VX, 1'b1, 1'b1);
					default: i = nop;
				endcase
			end
			MODE_BWD_EULER, MODE_SYMPLECTIC: begin
				unique case (pc)
					4'd0:    i = mk_mul((mode == MODE_BWD_EULER) ? SRC_GRAV : SRC_ACC,
							MB_DT, SH_16, DST_T, 1'b0, 1'b0);
					4'd1:    i = mk_alu(OP_ADD, SRC_VY, SRC_T, DST_VY, 1'b0, 1'b0);
					4'd2:    i = mk_mul(SRC_VX, MB_DT, SH_16, DST_T, 1'b1, 1'b0);
					4'd3:    i = mk_mul(SRC_T, MB_GAIN, SH_12, DST_T, 1'b1, 1'b0);
					4'd4:    i = mk_alu(OP_SUB, SRC_VX, SRC_T, DST_VX, 1'b1, 1'b0);
					4'd5:    i = mk_mul(SRC_VX, MB_DT, SH_16, DST_T, 1'b0, 1'b0);
					4'd6:    i = mk_alu(OP_ADD, SRC_PX, SRC_T, DST_PX, 1'b0, 1'b0);
					4'd7:    i = mk_mul(SRC_VY, MB_DT, SH_16, DST_T, 1'b0, 1'b0);
					4'd8:    i = mk_alu(OP_ADD, SRC_PY, SRC_T, DST_PY, 1'b0, 1'b1);
					default: i = nop;
				endcase
			end
			MODE_POS_VERLET: begin
				unique case (pc)
					4'd0:    i = mk_alu(OP_ADD, SRC_PX, SRC_PX, DST_T, 1'b0, 1'b0);
					4'd1:    i = mk_alu(OP_SUB, SRC_T, SRC_PPX, DST_T, 1'b0, 1'b0);
					4'd2:    i = mk_alu(OP_ADD, SRC_PX, SRC_ZERO, DST_PPX, 1'b0, 1'b0);
					4'd3:    i = mk_alu(OP_ADD, SRC_T, SRC_ZERO, DST_PX, 1'b0, 1'b0);
					4'd4:    i = mk_alu(OP_ADD, SRC_PY, SRC_PY, DST_T, 1'b0, 1'b0);
					4'd5:    i = mk_alu(OP_SUB, SRC_T, SRC_PPY, DST_T, 1'b0, 1'b0);
					4'd6:    i = mk_alu(OP_ADD, SRC_PY, SRC_ZERO, DST_PPY, 1'b0, 1'b0);
					4'd7:    i = mk_mul(SRC_GRAV, MB_DT, SH_16, DST_U, 1'b0, 1'b0);
					4'd8:    i = mk_mul(SRC_U, MB_DT, SH_16, DST_U, 1'b0, 1'b0);
					4'd9:    i = mk_alu(OP_ADD, SRC_T, SRC_U, DST_PY, 1'b0, 1'b1);
					default: i = nop;
				endcase
			end
			MODE_VEL_VERLET: begin
				unique case (pc)
					4'd0:    i = mk_mul(SRC_ACC, MB_DT, SH_17, DST_T, 1'b0, 1'b0);
					4'd1:    i = mk_alu(OP_ADD, SRC_VY, SRC_T, DST_U, 1'b0, 1'b0);
					4'd2:    i = mk_mul(SRC_VX, MB_DT, SH_16, DST_T, 1'b0, 1'b0);
					4'd3:    i = mk_alu(OP_ADD, SRC_PX, SRC_T, DST_PX, 1'b0, 1'b0);
					4'd4:    i = mk_mul(SRC_U, MB_DT, SH_16, DST_T, 1'b0, 1'b0);
					4'd5:    i = mk_alu(OP_ADD, SRC_PY, SRC_T, DST_PY, 1'b0, 1'b0);
					4'd6:    i = mk_mul(SRC_GRAV, MB_DT, SH_16, DST_T, 1'b0, 1'b0);
					4'd7:    i = mk_alu(OP_ADD, SRC_U, SRC_T, DST_VY, 1'b0, 1'b0);
					4'd8:    i = mk_mul(SRC_VX, MB_DT, SH_16, DST_T, 1'b1, 1'b0);
					4'd9:    i = mk_mul(SRC_T, MB_GAIN, SH_12, DST_T, 1'b1, 1'b0);
					4'd10:   i = mk_alu(OP_SUB, SRC_VX, SRC_T, DST_VX, 1'b1, 1'b0);
					4'd11:   i = mk_mul(SRC_VY, MB_DT, SH_16, DST_T, 1'b1, 1'b0);
					4'd12:   i = mk_mul(SRC_T, MB_GAIN, SH_12, DST_T, 1'b1, 1'b0);
					4'd13:   i = mk_alu(OP_SUB, SRC_VY, SRC_T, DST_VY, 1'b1, 1'b1);
					default: i = nop;
				endcase
			end
			default: i = nop;
		endcase
		return i;
	endfunction

endpackage

/* rtl/multi_mode_motion_integrator.sv */
// a load word, or a tick under an unused scheme, skips the steps and goes straight to done
// in a tick each product is registered before write back; an add or a skipped drag step is not
// a new word waits until the last one is done; one shared multiply and add unit runs every step
// the next word is taken while a finished result still waits at the output register
// reset clears position, velocity, prior position and acceleration, and loads register defaults
// ----------------------------------------------------------------------------
// multi_mode_motion_integrator
// two-dimensional point integrator (euler and verlet schemes) in signed fixed point,
// one shared saturating multiply and add unit stepped by a small sequencer
// ----------------------------------------------------------------------------
`include "multi_mode_motion_integrator_macros.svh"

module multi_mode_motion_integrator #(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS   = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration writes
	input  logic                                 cfg_wr_en,
	input  logic [1:0]                           cfg_index,
	input  logic [VALUE_WIDTH-1:0]               cfg_data,
	// input words
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 cmd,
	input  logic [mmi_pkg::DT_BITS-1:0]          frame_time,
	input  logic signed [VALUE_WIDTH-1:0]        load_pos_x,
	input  logic signed [VALUE_WIDTH-1:0]        load_pos_y,
	input  logic signed [VALUE_WIDTH-1:0]        load_vel_x,
	input  logic signed [VALUE_WIDTH-1:0]        load_vel_y,
	// result words
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [VALUE_WIDTH-1:0]        pos_x,
	output logic signed [VALUE_WIDTH-1:0]        pos_y,
	output logic signed [VALUE_WIDTH-1:0]        vel_x,
	output logic signed [VALUE_WIDTH-1:0]        vel_y,
	output logic                                 saturated
);

	localparam int VW = VALUE_WIDTH;
	localparam int PW = VW + mmi_pkg::DT_BITS;
	localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
	localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic [PW:0] NEG_LIM = {{(PW+1-VW){1'b0}}, 1'b1, {(VW-1){1'b0}}};
	localparam logic [PW:0] POS_LIM = NEG_LIM - 1'b1;
	localparam logic [VW-1:0] GRAV_RESET = VW'(64'(mmi_pkg::GRAVITY_RESET) << FRAC_BITS);

	// configuration registers
	logic [2:0]                        mode_q;
	logic [VW-1:0]                     grav_q;
	logic                              drag_en_q;
	logic [mmi_pkg::GAIN_BITS-1:0]     gain_q;

	// integrator state
	logic [VW-1:0] px_q, py_q, vx_q, vy_q, ppx_q, ppy_q, acc_q;
	logic [VW-1:0] t_q, u_q;

	// sequencer
	mmi_pkg::state_t               state_q;
	logic [mmi_pkg::PC_BITS-1:0]   pc_q;
	logic                          phase_q;
	logic                          clip_q;
	logic [mmi_pkg::DT_BITS-1:0]   dt_q;

	// shared unit
	logic [PW-1:0] prod_q;
	logic          neg_q;

	// output register
	logic          out_valid_q;
	logic [VW-1:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;
	logic          sat_q;

	mmi_pkg::instr_t instr;
	logic [VW-1:0]   a_val, b_val, mag;
	logic [mmi_pkg::DT_BITS-1:0] mul_b;
	logic [PW:0]     half, rnd, rmag;
	logic [4:0]      amt;
	logic [VW:0]     sum;
	logic [VW-1:0]   mul_res, alu_res, wb_val;
	logic            mul_clip, alu_clip, wb_clip;
	logic            in_acc, skip, wb_en, advance, out_free;

	assign in_stall = (state_q != mmi_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// step decode
	assign instr   = mmi_pkg::ucode(mode_q, pc_q);
	assign skip    = instr.drag_only && !drag_en_q;
	assign wb_en   = (state_q == mmi_pkg::ST_RUN) && !skip
		&& ((instr.op != mmi_pkg::OP_MUL) || phase_q);
	assign advance = (state_q == mmi_pkg::ST_RUN) && (skip || wb_en);

	// operand select
	function automatic logic [VW-1:0] pick(input mmi_pkg::src_t s,
		input logic [VW-1:0] px, input logic [VW-1:0] py, input logic [VW-1:0] vx,
		input logic [VW-1:0] vy, input logic [VW-1:0] ppx, input logic [VW-1:0] ppy,
		input logic [VW-1:0] acc, input logic [VW-1:0] grav, input logic [VW-1:0] t,
		input logic [VW-1:0] u);
		logic [VW-1:0] r;
		unique case (s)
			mmi_pkg::SRC_PX:   r = px;
			mmi_pkg::SRC_PY:   r = py;
			mmi_pkg::SRC_VX:   r = vx;
			mmi_pkg::SRC_VY:   r = vy;
			mmi_pkg::SRC_PPX:  r = ppx;
			mmi_pkg::SRC_PPY:  r = ppy;
			mmi_pkg::SRC_ACC:  r = acc;
			mmi_pkg::SRC_GRAV: r = grav;
			mmi_pkg::SRC_T:    r = t;
			mmi_pkg::SRC_U:    r = u;
			default:           r = '0;
		endcase
		return r;
	endfunction

	assign a_val = pick(instr.a, px_q, py_q, vx_q, vy_q, ppx_q, ppy_q, acc_q, grav_q, t_q, u_q);
	assign b_val = pick(instr.b, px_q, py_q, vx_q, vy_q, ppx_q, ppy_q, acc_q, grav_q, t_q, u_q);
	assign mul_b = (instr.mb == mmi_pkg::MB_GAIN) ? gain_q : dt_q;
	assign mag   = a_val[VW-1] ? (~a_val + VW'(1)) : a_val;

	// product register, first half of a multiply step
	always_ff @(posedge clk) begin
		if ((state_q == mmi_pkg::ST_RUN) && (instr.op == mmi_pkg::OP_MUL) && !phase_q) begin
			prod_q <= PW'(mag) * PW'(mul_b);
			neg_q  <= a_val[VW-1];
		end
	end

	// round half away from zero on the magnitude, then saturate
	always_comb begin
		amt  = mmi_pkg::shift_amt(instr.sh);
		half = (PW+1)'(1) << (amt - 5'd1);
		rnd  = {1'b0, prod_q} + half;
		rmag = rnd >> amt;
		mul_clip = 1'b0;
		if (neg_q) begin
			if (rmag > NEG_LIM) begin
				mul_clip = 1'b1;
				mul_res  = VMIN;
			end else begin
				mul_res = ~rmag[VW-1:0] + VW'(1);
			end
		end else begin
			if (rmag > POS_LIM) begin
				mul_clip = 1'b1;
				mul_res  = VMAX;
			end else begin
				mul_res = rmag[VW-1:0];
			end
		end
	end

	// saturating add and subtract
	always_comb begin
		if (instr.op == mmi_pkg::OP_SUB) begin
			sum = {a_val[VW-1], a_val} - {b_val[VW-1], b_val};
		end else begin
			sum = {a_val[VW-1], a_val} + {b_val[VW-1], b_val};
		end
		alu_clip = sum[VW] ^ sum[VW-1];
		if (alu_clip) begin
			alu_res = sum[VW] ? VMIN : VMAX;
		end else begin
			alu_res = sum[VW-1:0];
		end
	end

	assign wb_val  = (instr.op == mmi_pkg::OP_MUL) ? mul_res : alu_res;
	assign wb_clip = (instr.op == mmi_pkg::OP_MUL) ? mul_clip : alu_clip;

	// configuration and integrator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= mmi_pkg::MODE_FWD_EULER;
			grav_q    <= GRAV_RESET;
			drag_en_q <= 1'b1;
			gain_q    <= mmi_pkg::DRAG_GAIN_RESET;
			px_q      <= '0;
			py_q      <= '0;
			vx_q      <= '0;
			vy_q      <= '0;
			ppx_q     <= '0;
			ppy_q     <= '0;
			acc_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					mmi_pkg::REG_MODE:    mode_q    <= cfg_data[2:0];
					mmi_pkg::REG_GRAVITY: grav_q    <= cfg_data;
					mmi_pkg::REG_DRAG_EN: drag_en_q <= cfg_data[0];
					mmi_pkg::REG_GAIN:    gain_q    <= cfg_data[mmi_pkg::GAIN_BITS-1:0];
					default: ;
				endcase
			end
			// load word sets position, velocity and prior position
			if (in_acc && (cmd == mmi_pkg::CMD_LOAD)) begin
				px_q  <= load_pos_x;
				py_q  <= load_pos_y;
				vx_q  <= load_vel_x;
				vy_q  <= load_vel_y;
				ppx_q <= load_pos_x;
				ppy_q <= load_pos_y;
			end
			// step write back
			if (wb_en) begin
				unique case (instr.dst)
					mmi_pkg::DST_PX:  px_q  <= wb_val;
					mmi_pkg::DST_PY:  py_q  <= wb_val;
					mmi_pkg::DST_VX:  vx_q  <= wb_val;
					mmi_pkg::DST_VY:  vy_q  <= wb_val;
					mmi_pkg::DST_PPX: ppx_q <= wb_val;
					mmi_pkg::DST_PPY: ppy_q <= wb_val;
					default: ;
				endcase
			end
			// acceleration takes gravity once the scheme is done
			if (advance && instr.last) begin
				acc_q <= grav_q;
			end
		end
	end

	// scratch registers
	always_ff @(posedge clk) begin
		if (wb_en && (instr.dst == mmi_pkg::DST_T)) begin
			t_q <= wb_val;
		end
		if (wb_en && (instr.dst == mmi_pkg::DST_U)) begin
			u_q <= wb_val;
		end
		if (in_acc) begin
			dt_q <= frame_time;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmi_pkg::ST_IDLE;
			pc_q    <= '0;
			phase_q <= 1'b0;
			clip_q  <= 1'b0;
		end else begin
			unique case (state_q)
				mmi_pkg::ST_IDLE: begin
					if (in_acc) begin
						pc_q    <= '0;
						phase_q <= 1'b0;
						clip_q  <= 1'b0;
						if ((cmd == mmi_pkg::CMD_TICK) && (mode_q <= mmi_pkg::MODE_VEL_VERLET)) begin
							state_q <= mmi_pkg::ST_RUN;
						end else begin
							state_q <= mmi_pkg::ST_DONE;
						end
					end
				end
				mmi_pkg::ST_RUN: begin
					if (wb_en) begin
						clip_q <= clip_q | wb_clip;
					end
					if (advance) begin
						phase_q <= 1'b0;
						pc_q    <= pc_q + 1'b1;
						if (instr.last) begin
							state_q <= mmi_pkg::ST_DONE;
						end
					end else begin
						phase_q <= 1'b1;
					end
				end
				mmi_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= mmi_pkg::ST_IDLE;
					end
				end
				default: state_q <= mmi_pkg::ST_IDLE;
			endcase
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == mmi_pkg::ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if ((state_q == mmi_pkg::ST_DONE) && out_free) begin
			pos_x_q <= px_q;
			pos_y_q <= py_q;
			vel_x_q <= vx_q;
			vel_y_q <= vy_q;
			sat_q   <= clip_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign vel_x     = vel_x_q;
	assign vel_y     = vel_y_q;
	assign saturated = sat_q;

	// checks
	`MMI_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_q != mmi_pkg::ST_IDLE)
	`MMI_ASSERT_NEXT(a_done_gives_word, (state_q == mmi_pkg::ST_DONE) && out_free, out_valid_q)
	`MMI_ASSERT_NOW(a_phase_only_in_run, phase_q, state_q == mmi_pkg::ST_RUN)
	`MMI_ASSERT_NOW(a_phase_only_on_mul, phase_q, instr.op == mmi_pkg::OP_MUL)

endmodule

/* tb/multi_mode_motion_integrator_test.sv */
// ----------------------------------------------------------------------------
// multi_mode_motion_integrator_test
// self-checking bench for the 2d motion integrator: a local fixed-point model
// of the five schemes predicts every result word; both sides idle at random
// ----------------------------------------------------------------------------
module multi_mode_motion_integrator_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     VW        = 32;
	localparam int     VALUE_FRAC = 12;
	localparam int     DT_SHIFT  = 16;
	localparam longint VMAX      = 64'sd2147483647;
	localparam longint VMIN      = -VMAX - 1;

	typedef struct {
		logic signed [VW-1:0] px;
		logic signed [VW-1:0] py;
		logic signed [VW-1:0] vx;
		logic signed [VW-1:0] vy;
		logic                 sat;
	} motion_t;

	// dut pins, all driven from time zero
	logic                          clk        = 1'b0;
	logic                          arst_n     = 1'b0;
	logic                          cfg_wr_en  = 1'b0;
	logic [1:0]                    cfg_index  = mmi_pkg::REG_MODE;
	logic [VW-1:0]                 cfg_data   = '0;
	logic                          in_valid   = 1'b0;
	logic                          in_stall;
	logic                          cmd        = mmi_pkg::CMD_TICK;
	logic [mmi_pkg::DT_BITS-1:0]   frame_time = '0;
	logic signed [VW-1:0]          load_pos_x = '0;
	logic signed [VW-1:0]          load_pos_y = '0;
	logic signed [VW-1:0]          load_vel_x = '0;
	logic signed [VW-1:0]          load_vel_y = '0;
	logic                          out_valid;
	logic                          out_stall  = 1'b0;
	logic signed [VW-1:0]          pos_x;
	logic signed [VW-1:0]          pos_y;
	logic signed [VW-1:0]          vel_x;
	logic signed [VW-1:0]          vel_y;
	logic                          saturated;

	// model state and register copies
	longint     state_px  = 0;
	longint     state_py  = 0;
	longint     state_vx  = 0;
	longint     state_vy  = 0;
	longint     state_ppx = 0;
	longint     state_ppy = 0;
	longint     state_ay  = 0;
	logic [2:0] cfg_scheme  = mmi_pkg::MODE_FWD_EULER;
	longint     cfg_gravity = longint'(mmi_pkg::GRAVITY_RESET) << VALUE_FRAC;
	logic       cfg_drag    = 1'b1;
	longint     cfg_gain    = longint'(mmi_pkg::DRAG_GAIN_RESET);
	bit         clipped;

	motion_t expected_motion[$];
	int      mismatch_count = 0;
	int      tx_idle_pct    = 0;
	int      rx_stall_pct   = 0;
	int      hold_request   = 0;
	int      hold_left      = 0;
	int      stall_left     = 0;

	multi_mode_motion_integrator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.frame_time(frame_time),
		.load_pos_x(load_pos_x),
		.load_pos_y(load_pos_y),
		.load_vel_x(load_vel_x),
		.load_vel_y(load_vel_y),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.vel_x     (vel_x),
		.vel_y     (vel_y),
		.saturated (saturated)
	);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("[multi_mode_motion_integrator] ERROR");
		$finish;
	end

	function automatic void note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
	endfunction

	// saturating fixed-point primitives
	function automatic longint clamp_value(input longint v);
		if (v > VMAX) begin
			clipped = 1'b1;
			return VMAX;
		end
		if (v < VMIN) begin
			clipped = 1'b1;
			return VMIN;
		end
		return v;
	endfunction

	function automatic longint sat_add(input longint a, input longint b);
		return clamp_value(a + b);
	endfunction

	function automatic longint sat_sub(input longint a, input longint b);
		return clamp_value(a - b);
	endfunction

	// round(a*m/2^s), ties away from zero
	function automatic longint scale_mul(input longint a, input longint m, input int s);
		longint mag;
		longint r;
		mag = (a < 0) ? -a : a;
		r = (mag * m + (longint'(1) << (s - 1))) >>> s;
		return clamp_value((a < 0) ? -r : r);
	endfunction

	function automatic longint drag_damp(input longint v, input longint dt);
		return sat_sub(v, scale_mul(scale_mul(v, dt, DT_SHIFT), cfg_gain, mmi_pkg::GAIN_FRAC));
	endfunction

	// advance the model by one accepted word and queue its result
	function automatic void advance_motion(input logic c,
		input logic [mmi_pkg::DT_BITS-1:0] dt_bits,
		input logic signed [VW-1:0] lpx, input logic signed [VW-1:0] lpy,
		input logic signed [VW-1:0] lvx, input logic signed [VW-1:0] lvy);
		longint  dt;
		longint  hx;
		longint  hy;
		longint  ox;
		longint  oy;
		motion_t res;
		dt = longint'(dt_bits);
		clipped = 1'b0;
		if (c == mmi_pkg::CMD_LOAD) begin
			state_px  = longint'(lpx);
			state_py  = longint'(lpy);
			state_vx  = longint'(lvx);
			state_vy  = longint'(lvy);
			state_ppx = state_px;
			state_ppy = state_py;
		end else begin
			case (cfg_scheme)
				mmi_pkg::MODE_FWD_EULER: begin
					state_px = sat_add(state_px, scale_mul(state_vx, dt, DT_SHIFT));
					state_py = sat_add(state_py, scale_mul(state_vy, dt, DT_SHIFT));
					state_vy = sat_add(state_vy, scale_mul(state_ay, dt, DT_SHIFT));
					if (cfg_drag) state_vx = drag_damp(state_vx, dt);
					state_ay = cfg_gravity;
				end
				mmi_pkg::MODE_BWD_EULER, mmi_pkg::MODE_SYMPLECTIC: begin
					if (cfg_scheme == mmi_pkg::MODE_BWD_EULER) state_ay = cfg_gravity;
					state_vy = sat_add(state_vy, scale_mul(state_ay, dt, DT_SHIFT));
					if (cfg_drag) state_vx = drag_damp(state_vx, dt);
					state_px = sat_add(state_px, scale_mul(state_vx, dt, DT_SHIFT));
					state_py = sat_add(state_py, scale_mul(state_vy, dt, DT_SHIFT));
					if (cfg_scheme == mmi_pkg::MODE_SYMPLECTIC) state_ay = cfg_gravity;
				end
				mmi_pkg::MODE_POS_VERLET: begin
					state_ay = cfg_gravity;
					ox = state_px;
					oy = state_py;
					state_px = sat_sub(sat_add(ox, ox), state_ppx);
					state_py = sat_add(sat_sub(sat_add(oy, oy), state_ppy),
						scale_mul(scale_mul(state_ay, dt, DT_SHIFT), dt, DT_SHIFT));
					state_ppx = ox;
					state_ppy = oy;
				end
				mmi_pkg::MODE_VEL_VERLET: begin
					hx = state_vx;
					hy = sat_add(state_vy, scale_mul(state_ay, dt, DT_SHIFT + 1));
					state_px = sat_add(state_px, scale_mul(hx, dt, DT_SHIFT));
					state_py = sat_add(state_py, scale_mul(hy, dt, DT_SHIFT));
					state_ay = cfg_gravity;
					state_vx = hx;
					state_vy = sat_add(hy, scale_mul(state_ay, dt, DT_SHIFT));
					if (cfg_drag) begin
						state_vx = drag_damp(state_vx, dt);
						state_vy = drag_damp(state_vy, dt);
					end
				end
				// unused schemes leave the state alone
				default: ;
			endcase
		end
		res.px  = state_px[VW-1:0];
		res.py  = state_py[VW-1:0];
		res.vx  = state_vx[VW-1:0];
		res.vy  = state_vy[VW-1:0];
		res.sat = clipped;
		expected_motion.push_back(res);
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(9) == 0) return $urandom_range(60, 20);
		return $urandom_range(3, 1);
	endfunction

	// q20.12 value: mostly modest magnitudes, sometimes extremes or anything
	function automatic logic [VW-1:0] pick_value();
		logic [VW-1:0] v;
		case ($urandom_range(9))
			0: v = $urandom;
			1: v = VMAX[VW-1:0];
			2: v = VMIN[VW-1:0];
			default: begin
				v = $urandom_range(1 << 23);
				if ($urandom_range(1)) v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic logic [mmi_pkg::DT_BITS-1:0] pick_dt();
		case ($urandom_range(19))
			0: return '0;
			1: return '1;
			2, 3: return mmi_pkg::DT_BITS'($urandom);
			default: return mmi_pkg::DT_BITS'($urandom_range(4000, 500));
		endcase
	endfunction

	// result word checker
	always @(posedge clk) begin
		motion_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_motion.size() == 0) begin
				note_failure($sformatf("unexpected result word pos %0d,%0d vel %0d,%0d sat %0b",
					pos_x, pos_y, vel_x, vel_y, saturated));
			end else begin
				want = expected_motion.pop_front();
				if (pos_x !== want.px || pos_y !== want.py || vel_x !== want.vx ||
					vel_y !== want.vy || saturated !== want.sat) begin
					note_failure($sformatf(
						"exp pos %0d,%0d vel %0d,%0d sat %0b / got pos %0d,%0d vel %0d,%0d sat %0b",
						want.px, want.py, want.vx, want.vy, want.sat,
						pos_x, pos_y, vel_x, vel_y, saturated));
				end
			end
		end
	end

	// receiver stalls: random runs plus an occasional long hold-off
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if ($urandom_range(99) < rx_stall_pct) begin
			stall_left = pick_gap() - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// offer one word, hold it until taken, then maybe idle
	task automatic send_word(input logic c, input logic [mmi_pkg::DT_BITS-1:0] dt,
		input logic [VW-1:0] lpx, input logic [VW-1:0] lpy,
		input logic [VW-1:0] lvx, input logic [VW-1:0] lvy);
		int gap;
		in_valid   <= 1'b1;
		cmd        <= c;
		frame_time <= dt;
		load_pos_x <= lpx;
		load_pos_y <= lpy;
		load_vel_x <= lvx;
		load_vel_y <= lvy;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		advance_motion(c, dt, lpx, lpy, lvx, lvy);
		gap = ($urandom_range(99) < tx_idle_pct) ? pick_gap() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_tick(input logic [mmi_pkg::DT_BITS-1:0] dt);
		send_word(mmi_pkg::CMD_TICK, dt, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic send_load(input logic [VW-1:0] px, input logic [VW-1:0] py,
		input logic [VW-1:0] vx, input logic [VW-1:0] vy);
		send_word(mmi_pkg::CMD_LOAD, mmi_pkg::DT_BITS'($urandom), px, py, vx, vy);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_motion.size() != 0) @(posedge clk);
	endtask

	// write all four registers while the block is idle
	task automatic configure(input logic [2:0] mode, input logic [VW-1:0] grav,
		input logic drag, input logic [mmi_pkg::GAIN_BITS-1:0] gain);
		logic [VW-1:0] d;
		wait_drained();
		d = $urandom;
		d[2:0] = mode;
		cfg_wr_en <= 1'b1;
		cfg_index <= mmi_pkg::REG_MODE;
		cfg_data  <= d;
		@(posedge clk);
		cfg_index <= mmi_pkg::REG_GRAVITY;
		cfg_data  <= grav;
		@(posedge clk);
		d = $urandom;
		d[0] = drag;
		cfg_index <= mmi_pkg::REG_DRAG_EN;
		cfg_data  <= d;
		@(posedge clk);
		d = $urandom;
		d[mmi_pkg::GAIN_BITS-1:0] = gain;
		cfg_index <= mmi_pkg::REG_GAIN;
		cfg_data  <= d;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cfg_scheme  = mode;
		cfg_gravity = longint'($signed(grav));
		cfg_drag    = drag;
		cfg_gain    = longint'(gain);
	endtask

	// ticks and a load under the register defaults, starting from zero acceleration
	task automatic test_reset_defaults();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		send_tick(16'd4096);
		send_tick(16'd4096);
		send_load(32'sd40960, -32'sd81920, 32'sd409600, -32'sd204800);
		send_tick(16'd2000);
	endtask

	// full-scale loads and frame times, saturation in both directions
	task automatic test_field_extremes();
		send_load(VMAX[VW-1:0], VMAX[VW-1:0], VMAX[VW-1:0], VMAX[VW-1:0]);
		send_tick('1);
		send_load(VMIN[VW-1:0], VMIN[VW-1:0], VMIN[VW-1:0], VMIN[VW-1:0]);
		send_tick('1);
		send_tick('0);
		send_load('0, '0, '0, '0);
	endtask

	// one tick per scheme code, unused codes too; verlet picks up the stored prior
	task automatic test_every_scheme();
		logic [VW-1:0]                 grav;
		logic [mmi_pkg::GAIN_BITS-1:0] gain;
		for (int m = 0; m < 8; m++) begin
			grav = 32'sd8192000;
			if (m == mmi_pkg::MODE_POS_VERLET) grav = VMAX[VW-1:0];
			if (m == mmi_pkg::MODE_VEL_VERLET) grav = VMIN[VW-1:0];
			gain = mmi_pkg::DRAG_GAIN_RESET;
			if (m == mmi_pkg::MODE_BWD_EULER) gain = '0;
			if (m == mmi_pkg::MODE_SYMPLECTIC) gain = '1;
			configure(3'(m), grav, m[0] == 1'b0, gain);
			if (m == mmi_pkg::MODE_SYMPLECTIC || m == mmi_pkg::MODE_VEL_VERLET) begin
				send_load(32'sd204800, 32'sd409600, -32'sd102400, 32'sd51200);
			end
			send_tick(16'd3000);
		end
	endtask

	// phases of random settings, mostly well-formed trajectories
	task automatic test_random_phases();
		logic [2:0]                    mode;
		logic [VW-1:0]                 grav;
		logic [mmi_pkg::GAIN_BITS-1:0] gain;
		for (int p = 0; p < 9; p++) begin
			mode = (p < 5) ? 3'(p) : (($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
				: 3'($urandom_range(4)));
			case ($urandom_range(5))
				0: grav = $urandom;
				1: grav = ($urandom_range(1)) ? VMAX[VW-1:0] : VMIN[VW-1:0];
				default: begin
					grav = $urandom_range(5000 << VALUE_FRAC);
					if ($urandom_range(1)) grav = -grav;
				end
			endcase
			case ($urandom_range(4))
				0: gain = ($urandom_range(1)) ? '0 : '1;
				1: gain = mmi_pkg::GAIN_BITS'($urandom);
				default: gain = mmi_pkg::GAIN_BITS'($urandom_range(20 << mmi_pkg::GAIN_FRAC));
			endcase
			configure(mode, grav, $urandom_range(3) != 0, gain);
			case ($urandom_range(2))
				0: tx_idle_pct = 0;
				1: tx_idle_pct = 20;
				default: tx_idle_pct = 50;
			endcase
			case ($urandom_range(2))
				0: rx_stall_pct = 0;
				1: rx_stall_pct = 20;
				default: rx_stall_pct = 50;
			endcase
			send_load(pick_value(), pick_value(), pick_value(), pick_value());
			for (int i = 1; i < 70; i++) begin
				if ($urandom_range(99) < 12) begin
					send_load(pick_value(), pick_value(), pick_value(), pick_value());
				end else begin
					send_tick(pick_dt());
				end
			end
		end
	endtask

	// long receiver hold-off while words keep coming back to back
	task automatic test_back_pressure();
		configure(mmi_pkg::MODE_VEL_VERLET, 32'sd20480000, 1'b1, mmi_pkg::DRAG_GAIN_RESET);
		tx_idle_pct  = 0;
		rx_stall_pct = 10;
		send_load(32'sd0, 32'sd409600, 32'sd204800, -32'sd102400);
		hold_request = 400;
		for (int i = 0; i < 24; i++) begin
			if (i % 6 == 5) send_load(pick_value(), pick_value(), pick_value(), pick_value());
			else send_tick(pick_dt());
		end
	endtask

	initial begin
		int spin;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_field_extremes();
		test_every_scheme();
		test_random_phases();
		test_back_pressure();

		// drain, then watch for stray words
		in_valid <= 1'b0;
		spin = 0;
		while (expected_motion.size() != 0 && spin < 50000) begin
			@(posedge clk);
			spin++;
		end
		repeat (40) @(posedge clk);
		if (expected_motion.size() != 0) begin
			note_failure($sformatf("%0d result words never arrived", expected_motion.size()));
		end

		if (mismatch_count == 0) begin
			$display("[multi_mode_motion_integrator] OK");
		end else begin
			$display("[multi_mode_motion_integrator] ERROR");
		end
		$finish;
	end

endmodule
